### src/ivs_pkg.sv
// Shared constants and types for the integer viewport scaler.
// No dependencies; every other file imports this package.
package ivs_pkg;

	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;
	localparam int ASPECT_BITS = 16;
	localparam int ASPECT_FRAC = 12;
	localparam int ASPECT_ROUND = 1 << (ASPECT_FRAC - 1);

	localparam logic [2:0] REG_USE_CUSTOM    = 3'd0;
	localparam logic [2:0] REG_CUSTOM_WIDTH  = 3'd1;
	localparam logic [2:0] REG_CUSTOM_HEIGHT = 3'd2;
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;
	localparam logic [2:0] REG_ASPECT_Q12    = 3'd5;
	localparam logic [2:0] REG_LOCK_RATIO    = 3'd6;
	localparam logic [2:0] REG_ROTATED       = 3'd7;

	localparam int RST_CUSTOM_WIDTH  = 640;
	localparam int RST_CUSTOM_HEIGHT = 480;
	localparam int RST_FRAME_WIDTH   = 320;
	localparam int RST_FRAME_HEIGHT  = 240;
	localparam int RST_ASPECT_Q12    = 5461;

	typedef struct packed {
		logic custom;
		logic keep;
	} ivs_mode_t;

endpackage

### src/ivs_base.sv
// Base size stages: aspect multiply, then rounding, saturation, rotation and mode select.
// Depends on ivs_pkg.
module ivs_base import ivs_pkg::*; #(
	parameter int DIM_BITS = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DIM_BITS-1:0]    win_w,
	input  logic [DIM_BITS-1:0]    win_h,
	input  logic                   use_custom,
	input  logic [DIM_BITS-1:0]    custom_w,
	input  logic [DIM_BITS-1:0]    custom_h,
	input  logic [DIM_BITS-1:0]    frame_w,
	input  logic [DIM_BITS-1:0]    frame_h,
	input  logic [ASPECT_BITS-1:0] aspect,
	input  logic                   lock_ratio,
	input  logic                   rotated,
	output logic                   valid_s2,
	output logic [DIM_BITS-1:0]    win_w_s2,
	output logic [DIM_BITS-1:0]    win_h_s2,
	output logic [DIM_BITS-1:0]    base_w_s2,
	output logic [DIM_BITS-1:0]    base_h_s2,
	output ivs_mode_t              mode_s2
);

	localparam int PW = DIM_BITS + ASPECT_BITS;

	logic                valid_s1;
	logic [PW-1:0]       prod_s1;
	logic [DIM_BITS-1:0] win_w_s1;
	logic [DIM_BITS-1:0] win_h_s1;

	logic [PW:0]         round_sum;
	logic [DIM_BITS-1:0] asp_w;
	logic [DIM_BITS-1:0] raw_w;
	logic [DIM_BITS-1:0] raw_h;
	logic [DIM_BITS-1:0] bw;
	logic [DIM_BITS-1:0] bh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PW'(frame_h) * PW'(aspect);
			win_w_s1 <= win_w;
			win_h_s1 <= win_h;
		end
	end

	// Round half up, then saturate to the largest dimension.
	always_comb begin
		round_sum = (PW+1)'(prod_s1) + (PW+1)'(ASPECT_ROUND);
		if (|round_sum[PW:ASPECT_FRAC+DIM_BITS]) begin
			asp_w = '1;
		end else begin
			asp_w = round_sum[ASPECT_FRAC+DIM_BITS-1:ASPECT_FRAC];
		end
		if (use_custom) begin
			raw_w = custom_w;
			raw_h = custom_h;
		end else begin
			raw_w = (aspect == '0) ? frame_w : asp_w;
			raw_h = frame_h;
		end
		if (rotated) begin
			bw = raw_h;
			bh = raw_w;
		end else begin
			bw = raw_w;
			bh = raw_h;
		end
		// A zero base only gets forced to one outside custom mode.
		if (!use_custom) begin
			if (bw == '0) bw = DIM_BITS'(1);
			if (bh == '0) bh = DIM_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_w_s2     <= win_w_s1;
			win_h_s2     <= win_h_s1;
			base_w_s2    <= bw;
			base_h_s2    <= bh;
			mode_s2.custom <= use_custom;
			mode_s2.keep   <= lock_ratio;
		end
	end

endmodule

### src/ivs_div.sv
// Pipelined restoring divider for both axes, one quotient bit per stage.
// Carries window, base and mode alongside; depends on ivs_pkg.
module ivs_div import ivs_pkg::*; #(
	parameter int DIM_BITS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [DIM_BITS-1:0] win_w,
	input  logic [DIM_BITS-1:0] win_h,
	input  logic [DIM_BITS-1:0] base_w,
	input  logic [DIM_BITS-1:0] base_h,
	input  ivs_mode_t           mode,
	output logic                out_valid,
	output logic [DIM_BITS-1:0] out_quo_w,
	output logic [DIM_BITS-1:0] out_quo_h,
	output logic [DIM_BITS-1:0] out_base_w,
	output logic [DIM_BITS-1:0] out_base_h,
	output logic [DIM_BITS-1:0] out_win_w,
	output logic [DIM_BITS-1:0] out_win_h,
	output ivs_mode_t           out_mode
);

	localparam int D = DIM_BITS;

	logic [D-1:0]   valid_s;
	logic [D-1:0]   rem_w_s [D-1];
	logic [D-1:0]   rem_h_s [D-1];
	logic [D-1:0]   num_w_s [D];
	logic [D-1:0]   num_h_s [D];
	logic [D-1:0]   dvs_w_s [D];
	logic [D-1:0]   dvs_h_s [D];
	logic [D-1:0]   win_w_s [D];
	logic [D-1:0]   win_h_s [D];
	ivs_mode_t      mode_s  [D];
	logic [2*D-1:0] last_w;
	logic [2*D-1:0] last_h;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	function automatic logic [2*D-1:0] div_step(input logic [D-1:0] rem,
			input logic [D-1:0] num, input logic [D-1:0] dvs);
		logic [D:0]   shifted;
		logic [D+1:0] diff;
		logic         ge;
		logic [D-1:0] rem_n;
		shifted = {rem, num[D-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs};
		ge      = ~diff[D+1];
		rem_n   = ge ? diff[D-1:0] : shifted[D-1:0];
		return {rem_n, num[D-2:0], ge};
	endfunction

	assign last_w = div_step(rem_w_s[D-2], num_w_s[D-2], dvs_w_s[D-2]);
	assign last_h = div_step(rem_h_s[D-2], num_h_s[D-2], dvs_h_s[D-2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[D-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{rem_w_s[0], num_w_s[0]} <= div_step('0, win_w, base_w);
			{rem_h_s[0], num_h_s[0]} <= div_step('0, win_h, base_h);
			dvs_w_s[0] <= base_w;
			dvs_h_s[0] <= base_h;
			win_w_s[0] <= win_w;
			win_h_s[0] <= win_h;
			mode_s[0]  <= mode;
			for (int k = 1; k < D - 1; k++) begin
				{rem_w_s[k], num_w_s[k]} <= div_step(rem_w_s[k-1], num_w_s[k-1], dvs_w_s[k-1]);
				{rem_h_s[k], num_h_s[k]} <= div_step(rem_h_s[k-1], num_h_s[k-1], dvs_h_s[k-1]);
			end
			num_w_s[D-1] <= last_w[D-1:0];
			num_h_s[D-1] <= last_h[D-1:0];
			for (int k = 1; k < D; k++) begin
				dvs_w_s[k] <= dvs_w_s[k-1];
				dvs_h_s[k] <= dvs_h_s[k-1];
				win_w_s[k] <= win_w_s[k-1];
				win_h_s[k] <= win_h_s[k-1];
				mode_s[k]  <= mode_s[k-1];
			end
		end
	end

	assign out_valid  = valid_s[D-1];
	assign out_quo_w  = num_w_s[D-1];
	assign out_quo_h  = num_h_s[D-1];
	assign out_base_w = dvs_w_s[D-1];
	assign out_base_h = dvs_h_s[D-1];
	assign out_win_w  = win_w_s[D-1];
	assign out_win_h  = win_h_s[D-1];
	assign out_mode   = mode_s[D-1];

endmodule

### src/ivs_scale.sv
// Scale selection, base times scale, and centering offsets into the output register.
// Depends on ivs_pkg.
module ivs_scale import ivs_pkg::*; #(
	parameter int DIM_BITS = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [DIM_BITS-1:0]        quo_w,
	input  logic [DIM_BITS-1:0]        quo_h,
	input  logic [DIM_BITS-1:0]        base_w,
	input  logic [DIM_BITS-1:0]        base_h,
	input  logic [DIM_BITS-1:0]        win_w,
	input  logic [DIM_BITS-1:0]        win_h,
	input  ivs_mode_t                  mode,
	output logic                       out_valid,
	output logic [DIM_BITS-1:0]        vp_width,
	output logic [DIM_BITS-1:0]        vp_height,
	output logic signed [DIM_BITS-1:0] vp_x,
	output logic signed [DIM_BITS-1:0] vp_y
);

	localparam int D = DIM_BITS;

	logic         valid_s1;
	logic         valid_s2;
	logic [D-1:0] scale_w_s1;
	logic [D-1:0] scale_h_s1;
	logic [D-1:0] base_w_s1;
	logic [D-1:0] base_h_s1;
	logic [D-1:0] win_w_s1;
	logic [D-1:0] win_h_s1;
	logic [D-1:0] vw_s2;
	logic [D-1:0] vh_s2;
	logic [D-1:0] win_w_s2;
	logic [D-1:0] win_h_s2;

	logic [D-1:0]   qmin;
	logic [D-1:0]   sw;
	logic [D-1:0]   sh;
	logic [2*D-1:0] prod_w;
	logic [2*D-1:0] prod_h;
	logic signed [D:0] pad_w;
	logic signed [D:0] pad_h;
	logic signed [D:0] half_w;
	logic signed [D:0] half_h;

	// A zero quotient means the base exceeds the window, so that axis keeps its base.
	always_comb begin
		qmin = (quo_w < quo_h) ? quo_w : quo_h;
		if (mode.custom) begin
			sw = D'(1);
			sh = D'(1);
		end else if (mode.keep) begin
			sw = (qmin == '0) ? D'(1) : qmin;
			sh = sw;
		end else begin
			sw = (quo_w == '0) ? D'(1) : quo_w;
			sh = (quo_h == '0) ? D'(1) : quo_h;
		end
	end

	assign prod_w = (2*D)'(base_w_s1) * (2*D)'(scale_w_s1);
	assign prod_h = (2*D)'(base_h_s1) * (2*D)'(scale_h_s1);

	// Halve the padding toward zero: add one before the shift when negative.
	always_comb begin
		pad_w  = $signed({1'b0, win_w_s2}) - $signed({1'b0, vw_s2});
		pad_h  = $signed({1'b0, win_h_s2}) - $signed({1'b0, vh_s2});
		half_w = (pad_w + $signed({{D{1'b0}}, pad_w[D]})) >>> 1;
		half_h = (pad_h + $signed({{D{1'b0}}, pad_h[D]})) >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_w_s1 <= sw;
			scale_h_s1 <= sh;
			base_w_s1  <= base_w;
			base_h_s1  <= base_h;
			win_w_s1   <= win_w;
			win_h_s1   <= win_h;
			vw_s2      <= prod_w[D-1:0];
			vh_s2      <= prod_h[D-1:0];
			win_w_s2   <= win_w_s1;
			win_h_s2   <= win_h_s1;
			vp_width   <= vw_s2;
			vp_height  <= vh_s2;
			vp_x       <= half_w[D-1:0];
			vp_y       <= half_h[D-1:0];
		end
	end

endmodule

### src/integer_viewport_scaler_core.sv
// Integer viewport scaler: a transaction passes the base stages, the divider and
// the scale stages; one transaction is taken every cycle unless the output stalls.
// Most stages are in the divider, which resolves one quotient bit per stage.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Depends on ivs_pkg, ivs_base, ivs_div and ivs_scale.
module integer_viewport_scaler_core import ivs_pkg::*; #(
	parameter int DIM_BITS = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_BITS-1:0]       paddr,
	input  logic [DATA_BITS-1:0]       pwdata,
	output logic [DATA_BITS-1:0]       prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [DIM_BITS-1:0]        win_width,
	input  logic [DIM_BITS-1:0]        win_height,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [DIM_BITS-1:0]        vp_width,
	output logic [DIM_BITS-1:0]        vp_height,
	output logic signed [DIM_BITS-1:0] vp_x,
	output logic signed [DIM_BITS-1:0] vp_y
);

	logic                   use_custom_q;
	logic [DIM_BITS-1:0]    custom_w_q;
	logic [DIM_BITS-1:0]    custom_h_q;
	logic [DIM_BITS-1:0]    frame_w_q;
	logic [DIM_BITS-1:0]    frame_h_q;
	logic [ASPECT_BITS-1:0] aspect_q;
	logic                   lock_ratio_q;
	logic                   rotated_q;

	logic                   cfg_wr;
	logic [2:0]             reg_idx;
	logic                   adv;

	logic                   b_valid;
	logic [DIM_BITS-1:0]    b_win_w;
	logic [DIM_BITS-1:0]    b_win_h;
	logic [DIM_BITS-1:0]    b_base_w;
	logic [DIM_BITS-1:0]    b_base_h;
	ivs_mode_t              b_mode;

	logic                   d_valid;
	logic [DIM_BITS-1:0]    d_quo_w;
	logic [DIM_BITS-1:0]    d_quo_h;
	logic [DIM_BITS-1:0]    d_base_w;
	logic [DIM_BITS-1:0]    d_base_h;
	logic [DIM_BITS-1:0]    d_win_w;
	logic [DIM_BITS-1:0]    d_win_h;
	ivs_mode_t              d_mode;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_custom_q  <= 1'b0;
			custom_w_q    <= DIM_BITS'(RST_CUSTOM_WIDTH);
			custom_h_q    <= DIM_BITS'(RST_CUSTOM_HEIGHT);
			frame_w_q     <= DIM_BITS'(RST_FRAME_WIDTH);
			frame_h_q     <= DIM_BITS'(RST_FRAME_HEIGHT);
			aspect_q      <= ASPECT_BITS'(RST_ASPECT_Q12);
			lock_ratio_q  <= 1'b1;
			rotated_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_USE_CUSTOM:    use_custom_q  <= pwdata[0];
				REG_CUSTOM_WIDTH:  custom_w_q    <= pwdata[DIM_BITS-1:0];
				REG_CUSTOM_HEIGHT: custom_h_q    <= pwdata[DIM_BITS-1:0];
				REG_FRAME_WIDTH:   frame_w_q     <= pwdata[DIM_BITS-1:0];
				REG_FRAME_HEIGHT:  frame_h_q     <= pwdata[DIM_BITS-1:0];
				REG_ASPECT_Q12:    aspect_q      <= pwdata[ASPECT_BITS-1:0];
				REG_LOCK_RATIO:    lock_ratio_q  <= pwdata[0];
				REG_ROTATED:       rotated_q     <= pwdata[0];
				default:           use_custom_q  <= use_custom_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_USE_CUSTOM:    prdata = DATA_BITS'(use_custom_q);
			REG_CUSTOM_WIDTH:  prdata = DATA_BITS'(custom_w_q);
			REG_CUSTOM_HEIGHT: prdata = DATA_BITS'(custom_h_q);
			REG_FRAME_WIDTH:   prdata = DATA_BITS'(frame_w_q);
			REG_FRAME_HEIGHT:  prdata = DATA_BITS'(frame_h_q);
			REG_ASPECT_Q12:    prdata = DATA_BITS'(aspect_q);
			REG_LOCK_RATIO:    prdata = DATA_BITS'(lock_ratio_q);
			REG_ROTATED:       prdata = DATA_BITS'(rotated_q);
			default:           prdata = '0;
		endcase
	end

	// The pipeline moves whenever the output register is empty or being drained.
	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv;

	ivs_base #(.DIM_BITS(DIM_BITS)) u_base (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (in_valid),
		.win_w       (win_width),
		.win_h       (win_height),
		.use_custom  (use_custom_q),
		.custom_w    (custom_w_q),
		.custom_h    (custom_h_q),
		.frame_w     (frame_w_q),
		.frame_h     (frame_h_q),
		.aspect      (aspect_q),
		.lock_ratio  (lock_ratio_q),
		.rotated     (rotated_q),
		.valid_s2    (b_valid),
		.win_w_s2    (b_win_w),
		.win_h_s2    (b_win_h),
		.base_w_s2   (b_base_w),
		.base_h_s2   (b_base_h),
		.mode_s2     (b_mode)
	);

	ivs_div #(.DIM_BITS(DIM_BITS)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (b_valid),
		.win_w      (b_win_w),
		.win_h      (b_win_h),
		.base_w     (b_base_w),
		.base_h     (b_base_h),
		.mode       (b_mode),
		.out_valid  (d_valid),
		.out_quo_w  (d_quo_w),
		.out_quo_h  (d_quo_h),
		.out_base_w (d_base_w),
		.out_base_h (d_base_h),
		.out_win_w  (d_win_w),
		.out_win_h  (d_win_h),
		.out_mode   (d_mode)
	);

	ivs_scale #(.DIM_BITS(DIM_BITS)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d_valid),
		.quo_w     (d_quo_w),
		.quo_h     (d_quo_h),
		.base_w    (d_base_w),
		.base_h    (d_base_h),
		.win_w     (d_win_w),
		.win_h     (d_win_h),
		.mode      (d_mode),
		.out_valid (out_valid),
		.vp_width  (vp_width),
		.vp_height (vp_height),
		.vp_x      (vp_x),
		.vp_y      (vp_y)
	);

endmodule
